### rtl/core/gbd_pkg.sv
// types, codes and rule functions shared by the grapheme boundary detector
package gbd_pkg;

  // grapheme break classes, plus the carried code for a pictographic run ended by zwj
  typedef enum logic [3:0] {
    CLS_OTHER       = 4'd0,
    CLS_CR          = 4'd1,
    CLS_LF          = 4'd2,
    CLS_CONTROL     = 4'd3,
    CLS_EXTEND      = 4'd4,
    CLS_ZWJ         = 4'd5,
    CLS_REGIONAL    = 4'd6,
    CLS_PREPEND     = 4'd7,
    CLS_SPACINGMARK = 4'd8,
    CLS_L           = 4'd9,
    CLS_V           = 4'd10,
    CLS_T           = 4'd11,
    CLS_LV          = 4'd12,
    CLS_LVT         = 4'd13,
    CLS_PICTO       = 4'd14,
    CLS_PICTO_ZWJ   = 4'd15
  } class_e;

  // indic conjunct classes and tracking states
  typedef enum logic [1:0] {
    IC_NONE      = 2'd0,
    IC_CONSONANT = 2'd1,
    IC_EXTEND    = 2'd2,
    IC_LINKER    = 2'd3
  } conj_e;

  // cr, lf or control
  function automatic logic is_ctl(class_e c);
    return (c == CLS_CR) || (c == CLS_LF) || (c == CLS_CONTROL);
  endfunction

  // pairwise break rule between the carried class and the incoming class
  function automatic logic pair_breaks(class_e l, class_e r);
    logic brk;
    brk = 1'b1;
    if (l == CLS_CR && r == CLS_LF) begin
      brk = 1'b0;
    end else if (is_ctl(l) || is_ctl(r)) begin
      brk = 1'b1;
    end else if (l == CLS_L &&
                 (r == CLS_L || r == CLS_V || r == CLS_LV || r == CLS_LVT)) begin
      brk = 1'b0;
    end else if ((l == CLS_LV || l == CLS_V) && (r == CLS_V || r == CLS_T)) begin
      brk = 1'b0;
    end else if ((l == CLS_LVT || l == CLS_T) && r == CLS_T) begin
      brk = 1'b0;
    end else if (r == CLS_EXTEND || r == CLS_ZWJ || r == CLS_SPACINGMARK ||
                 l == CLS_PREPEND) begin
      brk = 1'b0;
    end else if (l == CLS_PICTO_ZWJ && r == CLS_PICTO) begin
      brk = 1'b0;
    end else if (l == CLS_REGIONAL && r == CLS_REGIONAL) begin
      brk = 1'b0;
    end
    return brk;
  endfunction

endpackage

### rtl/core/gbd_in_if.sv
// input channel: one classified code point word per handshake
interface gbd_in_if
  import gbd_pkg::*;
();
  logic   valid;
  logic   ready;
  class_e break_class;
  conj_e  conjunct_class;
  logic   first_of_text;

  modport source (output valid, output break_class, output conjunct_class,
                  output first_of_text, input ready);
  modport sink   (input valid, input break_class, input conjunct_class,
                  input first_of_text, output ready);
endinterface

### rtl/core/gbd_out_if.sv
// output channel: one boundary flag word per handshake
interface gbd_out_if;
  logic valid;
  logic ready;
  logic boundary_before;

  modport source (output valid, output boundary_before, input ready);
  modport sink   (input valid, input boundary_before, output ready);
endinterface

### rtl/core/grapheme_boundary_detector.sv
// grapheme cluster boundary detector top level
// an accepted word passes through the input register, then the result register
// throughput: one word per cycle while the output is ready, limited by the state update loop
// the input register refills while a finished result waits in the result register
// reset: asynchronous active low; carried class clears to other, conjunct state to none
// valid flags clear on reset; payload registers are not reset
module grapheme_boundary_detector
  import gbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  gbd_in_if.sink    in_i,
  gbd_out_if.source out_o
);

  logic   s1_valid_q;
  class_e s1_class_q;
  conj_e  s1_conj_q;
  logic   s1_first_q;
  logic   s1_adv;

  class_e carried_q, carried_d;
  conj_e  conj_q, conj_d;

  logic   out_valid_q;
  logic   out_bnd_q;

  class_e bc;
  class_e sc_next;
  conj_e  si_next;
  logic   brk;

  // handshake: stage 1 moves on when the result register is free or draining
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_class_q <= in_i.break_class;
      s1_conj_q  <= in_i.conjunct_class;
      s1_first_q <= in_i.first_of_text;
    end
  end

  // boundary decision and next cluster state
  always_comb begin
    bc = (s1_class_q == CLS_PICTO_ZWJ) ? CLS_OTHER : s1_class_q;
    brk = s1_first_q ||
          (pair_breaks(carried_q, bc) && !(conj_q == IC_LINKER && s1_conj_q == IC_CONSONANT));

    // indic conjunct linker tracking
    si_next = conj_q;
    if (s1_conj_q == IC_CONSONANT || conj_q == IC_CONSONANT || conj_q == IC_EXTEND) begin
      si_next = s1_conj_q;
    end else if (conj_q == IC_LINKER) begin
      si_next = (s1_conj_q == IC_EXTEND) ? IC_LINKER : s1_conj_q;
    end

    // carried class: regional pairs close, pictographic runs over extend and zwj
    if (carried_q == CLS_REGIONAL && bc == CLS_REGIONAL) begin
      sc_next = CLS_OTHER;
    end else if (carried_q == CLS_PICTO) begin
      sc_next = (bc == CLS_EXTEND) ? CLS_PICTO :
                (bc == CLS_ZWJ)    ? CLS_PICTO_ZWJ : bc;
    end else begin
      sc_next = bc;
    end

    // a boundary reloads the state from this code point
    if (brk) begin
      carried_d = bc;
      conj_d    = (s1_conj_q == IC_CONSONANT) ? IC_CONSONANT : IC_NONE;
    end else begin
      carried_d = sc_next;
      conj_d    = si_next;
    end
  end

  // cluster state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carried_q <= CLS_OTHER;
      conj_q    <= IC_NONE;
    end else if (s1_adv) begin
      carried_q <= carried_d;
      conj_q    <= conj_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_bnd_q <= brk;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.boundary_before = out_bnd_q;

`ifndef SYNTHESIS
  // a first-of-text word always yields a boundary
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_first_q |=> out_bnd_q)
    else $error("first of text did not give a boundary");

  // after a boundary the conjunct state is only none or consonant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && brk |=> (conj_q == IC_NONE || conj_q == IC_CONSONANT))
    else $error("conjunct state not reloaded on boundary");

  // a result appears only after stage 1 moved a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv))
    else $error("result valid without a word from stage 1");

  // state holds while stage 1 does not advance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(carried_q) && $stable(conj_q))
    else $error("cluster state changed without an advancing word");
`endif

endmodule
